/* rtl/btd_pkg.sv */
// ----------------------------------------------------------------------------
// btd_pkg: shared types and name tables of the basic token detokenizer
// keyword and function name tables, parse phases and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package btd_pkg;

  localparam int unsigned MaxChars  = 8;
  localparam int unsigned KwCount   = 109;
  localparam int unsigned FnCount   = 51;
  localparam int unsigned MaxDigits = 5;
  // reciprocal of ten for 16-bit values: q = (v * RecipTen) >> RecipShift
  localparam int unsigned RecipTen   = 52429;
  localparam int unsigned RecipShift = 19;

  localparam logic [7:0] ChrNewline = 8'h0a;
  localparam logic [7:0] ChrSpace   = 8'h20;
  localparam logic [7:0] CodePrefix = 8'hff;
  localparam logic [7:0] CodeSkip   = 8'h01;
  localparam logic [7:0] CodeEol    = 8'h00;
  localparam logic [7:0] CodeToken  = 8'h80;

  typedef enum logic [3:0] {
    PH_NORMAL   = 4'd0,
    PH_LINK1    = 4'd1,
    PH_LINK2    = 4'd2,
    PH_LINE_HI  = 4'd3,
    PH_LINE_LO  = 4'd4,
    PH_AFTERNUM = 4'd5,
    PH_SKIP1    = 4'd6,
    PH_SKIP2    = 4'd7,
    PH_SKIP3    = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CONV = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  // keyword names, right aligned, zero padded
  function automatic logic [55:0] kw_text(input logic [6:0] idx);
    logic [55:0] t;
    case (idx)
      7'd0:   t = "END";     7'd1:   t = "FOR";     7'd2:   t = "NEXT";
      7'd3:   t = "DATA";    7'd4:   t = "DIM";     7'd5:   t = "READ";
      7'd6:   t = "LET";     7'd7:   t = "GO";      7'd8:   t = "RUN";
      7'd9:   t = "IF";      7'd10:  t = "RESTORE"; 7'd11:  t = "RETURN";
      7'd12:  t = "REM";     7'd13:  t = "'";       7'd14:  t = "STOP";
      7'd15:  t = "ELSE";    7'd16:  t = "TRON";    7'd17:  t = "TROFF";
      7'd18:  t = "DEFSTR";  7'd19:  t = "DEFINT";  7'd20:  t = "DEFSNG";
      7'd21:  t = "DEFDBL";  7'd22:  t = "ON";      7'd23:  t = "WAIT";
      7'd24:  t = "ERROR";   7'd25:  t = "RESUME";  7'd26:  t = "AUTO";
      7'd27:  t = "DELETE";  7'd28:  t = "LOCATE";  7'd29:  t = "CLS";
      7'd30:  t = "CONSOLE"; 7'd31:  t = "PSET";    7'd32:  t = "MOTOR";
      7'd33:  t = "SKIP";    7'd34:  t = "EXEC";    7'd35:  t = "BEEP";
      7'd36:  t = "COLOR";   7'd37:  t = "LINE";    7'd38:  t = "BOX";
      7'd39:  t = "UNMASK";  7'd40:  t = "ATTRB";   7'd41:  t = "DEF";
      7'd42:  t = "POKE";    7'd43:  t = "PRINT";   7'd44:  t = "CONT";
      7'd45:  t = "LIST ";   7'd46:  t = "CLEAR";   7'd47:  t = "WHILE ";
      7'd48:  t = "WHEN";    7'd49:  t = "NEW";     7'd50:  t = "SAVE";
      7'd51:  t = "LOAD";    7'd52:  t = "MERGE";   7'd53:  t = "OPEN";
      7'd54:  t = "CLOSE ";  7'd55:  t = "INPEN";   7'd56:  t = "PEN";
      7'd57:  t = "PLAY";    7'd58:  t = "TAB(";    7'd59:  t = "TO";
      7'd60:  t = "SUB";     7'd61:  t = "FN";      7'd62:  t = "SPC(";
      7'd63:  t = "USING";   7'd64:  t = "USR";     7'd65:  t = "ERL";
      7'd66:  t = "ERR";     7'd67:  t = "OFF";     7'd68:  t = "THEN ";
      7'd69:  t = "NOT";     7'd70:  t = "STEP";    7'd71:  t = "+";
      7'd72:  t = "-";       7'd73:  t = "*";       7'd74:  t = "/";
      7'd75:  t = "^";       7'd76:  t = "AND";     7'd77:  t = "OR";
      7'd78:  t = "XOR";     7'd79:  t = "EQV";     7'd80:  t = "IMP";
      7'd81:  t = "MOD";     7'd82:  t = "@";       7'd83:  t = ">";
      7'd84:  t = "=";       7'd85:  t = "<";       7'd86:  t = "DSKINI";
      7'd87:  t = "DSKO$";   7'd88:  t = "KILL";    7'd89:  t = "NAME";
      7'd90:  t = "FIELD";   7'd91:  t = "LSET";    7'd92:  t = "RSET";
      7'd93:  t = "PUT";     7'd94:  t = "GET";     7'd95:  t = "VERIFY";
      7'd96:  t = "DEVICE";  7'd97:  t = "DIR";     7'd98:  t = "FILES";
      7'd99:  t = "WRITE";   7'd100: t = "UNLOAD";  7'd101: t = "BACKUP";
      7'd102: t = "COPY";    7'd103: t = "CIRCLE";  7'd104: t = "PAINT";
      7'd105: t = "DRAW";    7'd106: t = "RENUM";   7'd107: t = "SWAP";
      7'd108: t = "DENSITY";
      default: t = '0;
    endcase
    return t;
  endfunction

  // function names, right aligned, zero padded
  function automatic logic [55:0] fn_text(input logic [6:0] idx);
    logic [55:0] t;
    case (idx)
      7'd0:  t = "SGN";     7'd1:  t = "INT";     7'd2:  t = "ABS";
      7'd3:  t = "FRE";     7'd4:  t = "SQR";     7'd5:  t = "LOG";
      7'd6:  t = "EXP";     7'd7:  t = "COS";     7'd8:  t = "SIN";
      7'd9:  t = "TAN";     7'd10: t = "PEEK";    7'd11: t = "LEN";
      7'd12: t = "STR$";    7'd13: t = "VAL";     7'd14: t = "ASC";
      7'd15: t = "CHR$";    7'd16: t = "EOF";     7'd17: t = "CINT";
      7'd18: t = "CSNG";    7'd19: t = "CDBL";    7'd20: t = "FIX";
      7'd21: t = "HEX$";    7'd22: t = "OCT$";    7'd23: t = "STICK";
      7'd24: t = "STRIG";   7'd25: t = "GR$";     7'd26: t = "LEFT$";
      7'd27: t = "RIGHT$";  7'd28: t = "MID$";    7'd29: t = "INSTR";
      7'd30: t = "VARPTR";  7'd31: t = "RND";     7'd32: t = "INKEY$";
      7'd33: t = "INPUT";   7'd34: t = "CSRLIN";  7'd35: t = "POINT";
      7'd36: t = "SCREEN";  7'd37: t = "POS";     7'd38: t = "PTRIG";
      7'd39: t = "DSKL";    7'd40: t = "CVI";     7'd41: t = "CVS";
      7'd42: t = "CVD";     7'd43: t = "MKI$";    7'd44: t = "MKS$";
      7'd45: t = "MKD$";    7'd46: t = "LOC";     7'd47: t = "LOF";
      7'd48: t = "SPACE$";  7'd49: t = "STRING$"; 7'd50: t = "DSKI$";
      default: t = '0;
    endcase
    return t;
  endfunction

  // number of characters in a right-aligned zero-padded text
  function automatic logic [3:0] text_len(input logic [63:0] t);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (t[8*i +: 8] != 8'h00) begin
        n = n + 4'd1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/btd_in_if.sv */
// ----------------------------------------------------------------------------
// btd_in_if: input byte channel
// valid/ready handshake carrying one program byte
// ----------------------------------------------------------------------------
`default_nettype none

interface btd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

/* rtl/btd_out_if.sv */
// ----------------------------------------------------------------------------
// btd_out_if: output character channel
// valid/ready handshake carrying one listing character
// ----------------------------------------------------------------------------
`default_nettype none

interface btd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

/* rtl/basic_token_detokenizer.sv */
// ----------------------------------------------------------------------------
// basic_token_detokenizer: tokenized BASIC byte stream to listing text
// decodes one program byte per item into up to eight ASCII characters
// ----------------------------------------------------------------------------
// a byte is decoded in the cycle it is accepted; its first character shows the
//   next cycle, or after up to 5 divide-by-ten steps for a line number; a new
//   byte is taken only while idle, once all characters of the last one have left
//   the output port, where one character leaves per cycle while it is ready
// reset (rst, synchronous): normal text phase, no prefix, no output pending
`default_nettype none

module basic_token_detokenizer (
  input  wire logic  clk,
  input  wire logic  rst,
  btd_in_if.sink     in_ch,
  btd_out_if.source  out_ch
);

  // parse state
  btd_pkg::phase_t phase, phase_next;
  logic            prefix, prefix_next;
  logic [7:0]      line_hi, line_hi_next;

  // sequencer state
  btd_pkg::state_t state, state_next;
  logic [63:0]     text, text_next;     // characters, first one at byte len-1
  logic [3:0]      len, len_next;       // characters left
  logic [15:0]     val, val_next;       // line number still to convert
  logic [2:0]      ndig, ndig_next;     // digits produced so far

  logic        accept;
  logic [7:0]  b;
  logic [6:0]  idx;
  logic [55:0] kw, fn;

  // divide-by-ten unit: reciprocal multiply
  logic [32:0] prod;
  logic [15:0] quo;
  logic [3:0]  digit;

  assign accept = in_ch.valid && in_ch.ready;
  assign b      = in_ch.in_byte;
  assign idx    = b[6:0];
  assign kw     = btd_pkg::kw_text(idx);
  assign fn     = btd_pkg::fn_text(idx);

  assign prod  = {17'd0, val} * 33'(btd_pkg::RecipTen);
  assign quo   = prod[btd_pkg::RecipShift +: 16];
  assign digit = 4'(val - 16'(quo * 16'd10));

  // handshake: byte taken only when idle, a character shown while emitting
  assign in_ch.ready      = (state == btd_pkg::ST_IDLE);
  assign out_ch.valid     = (state == btd_pkg::ST_EMIT);
  assign out_ch.out_char  = text[8*(3'(len - 4'd1)) +: 7];
  assign out_ch.last_char = (len == 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= btd_pkg::ST_IDLE;
      phase   <= btd_pkg::PH_NORMAL;
      prefix  <= 1'b0;
      line_hi <= '0;
      len     <= '0;
      ndig    <= '0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      prefix  <= prefix_next;
      line_hi <= line_hi_next;
      len     <= len_next;
      ndig    <= ndig_next;
    end
  end

  always_ff @(posedge clk) begin
    text <= text_next;
    val  <= val_next;
  end

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    prefix_next  = prefix;
    line_hi_next = line_hi;
    text_next    = text;
    len_next     = len;
    val_next     = val;
    ndig_next    = ndig;

    case (state)
      btd_pkg::ST_IDLE: begin
        if (accept) begin
          len_next = '0;
          case (phase)
            btd_pkg::PH_LINK1:   phase_next = btd_pkg::PH_LINK2;
            btd_pkg::PH_LINK2:   phase_next = btd_pkg::PH_LINE_HI;
            btd_pkg::PH_LINE_HI: begin
              line_hi_next = b;
              phase_next   = btd_pkg::PH_LINE_LO;
            end
            btd_pkg::PH_LINE_LO: begin
              // number text starts as the trailing space, digits stack above it
              val_next   = {line_hi, b};
              text_next  = {56'd0, btd_pkg::ChrSpace};
              len_next   = 4'd1;
              ndig_next  = '0;
              phase_next = btd_pkg::PH_AFTERNUM;
              state_next = btd_pkg::ST_CONV;
            end
            btd_pkg::PH_SKIP1:   phase_next = btd_pkg::PH_SKIP2;
            btd_pkg::PH_SKIP2:   phase_next = btd_pkg::PH_SKIP3;
            btd_pkg::PH_SKIP3:   phase_next = btd_pkg::PH_NORMAL;
            default: begin
              phase_next = btd_pkg::PH_NORMAL;
              if (b == btd_pkg::CodeEol && phase != btd_pkg::PH_AFTERNUM) begin
                // end of line: newline, then link bytes and line number
                text_next  = {56'd0, btd_pkg::ChrNewline};
                len_next   = 4'd1;
                phase_next = btd_pkg::PH_LINK1;
              end else if (b >= btd_pkg::ChrSpace && b < btd_pkg::CodeToken) begin
                text_next = {56'd0, b};
                len_next  = 4'd1;
              end else if (b == btd_pkg::CodePrefix) begin
                prefix_next = 1'b1;
              end else if (b >= btd_pkg::CodeToken) begin
                if (!prefix) begin
                  // keyword plus trailing space; unknown codes give nothing
                  if (32'(idx) < btd_pkg::KwCount) begin
                    text_next = {kw, btd_pkg::ChrSpace};
                    len_next  = btd_pkg::text_len({8'd0, kw}) + 4'd1;
                  end
                end else begin
                  if (32'(idx) < btd_pkg::FnCount) begin
                    text_next = {8'd0, fn};
                    len_next  = btd_pkg::text_len({8'd0, fn});
                  end
                  prefix_next = 1'b0;
                end
              end else if (b == btd_pkg::CodeSkip && prefix) begin
                phase_next  = btd_pkg::PH_SKIP1;
                prefix_next = 1'b0;
              end
            end
          endcase
          if (phase != btd_pkg::PH_LINE_LO && len_next != 4'd0) begin
            state_next = btd_pkg::ST_EMIT;
          end
        end
      end

      btd_pkg::ST_CONV: begin
        // one decimal digit per cycle, least significant first
        text_next[8*len[2:0] +: 8] = {4'h3, digit};
        len_next  = len + 4'd1;
        ndig_next = ndig + 3'd1;
        val_next  = quo;
        if (quo == 16'd0 || 32'(ndig) == btd_pkg::MaxDigits - 1) begin
          state_next = btd_pkg::ST_EMIT;
        end
      end

      btd_pkg::ST_EMIT: begin
        if (out_ch.ready) begin
          len_next = len - 4'd1;
          if (len == 4'd1) begin
            state_next = btd_pkg::ST_IDLE;
          end
        end
      end

      default: state_next = btd_pkg::ST_IDLE;
    endcase
  end

  // emitting always has a character left
  a_emit_len: assert property (@(posedge clk) disable iff (rst)
    state == btd_pkg::ST_EMIT |-> (len != 4'd0 && 32'(len) <= btd_pkg::MaxChars))
    else $error("emit with bad character count");

  // a line number never needs more than five digits
  a_conv_digits: assert property (@(posedge clk) disable iff (rst)
    state == btd_pkg::ST_CONV |-> 32'(ndig) < btd_pkg::MaxDigits)
    else $error("too many digits");

  // the last character of an item returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last_char) |=> state == btd_pkg::ST_IDLE)
    else $error("not idle after last character");

endmodule

`default_nettype wire
